>>> sv/alpha_over_composite_defines.svh
// Assertion macros shared by the alpha-over compositing block.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ALPHA_OVER_COMPOSITE_DEFINES_SVH
`define ALPHA_OVER_COMPOSITE_DEFINES_SVH

// Implication checked in the same cycle.
`define AOC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define AOC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/aoc_pkg.sv
// Shared types and constants of the alpha-over compositing block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aoc_pkg;

  localparam int PixW   = 8;
  localparam int NumW   = 24;
  localparam int DivW   = 16;
  localparam int NLanes = 4;
  localparam int LaneA  = 3;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 8;

  localparam logic [PixW-1:0] PixMax = 8'd255;

  // Rounded division by 255 as a reciprocal multiply: floor((x + 127) * 32897 / 2^23).
  localparam logic [DivW:0]   HalfPix  = 17'd127;
  localparam logic [DivW-1:0] Rcp255   = 16'd32897;
  localparam int              Rcp255Sh = 23;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FG_HAS_ALPHA = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_BG_HAS_ALPHA = 8'd1;

  // One division job: quotient num / div, rounded and saturated.
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DivW-1:0] div;
  } lane_t;

  // One queued pixel request: blue, green, red, alpha lanes.
  typedef lane_t [NLanes-1:0] entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic vld;
  } q_stat_t;

endpackage

>>> sv/alpha_over_composite.sv
// Pipeline: two front stages (the first loads at the start edge), the queue slot,
// the divider input register, eight divider stages and the output register; the
// result strobe is registered together with the output register.
// Throughput: one pixel per clock while busy is low; the divider is fully
// pipelined, one quotient bit per stage on four lanes. The receiver cannot
// stall. Reset: asynchronous, active low; both alpha enables reset to 1.
`timescale 1ns / 1ps

module alpha_over_composite
  import aoc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic               in_overlap_i,
  input  logic [PixW-1:0]    fg_blue_i,
  input  logic [PixW-1:0]    fg_green_i,
  input  logic [PixW-1:0]    fg_red_i,
  input  logic [PixW-1:0]    fg_alpha_i,
  input  logic [PixW-1:0]    bg_blue_i,
  input  logic [PixW-1:0]    bg_green_i,
  input  logic [PixW-1:0]    bg_red_i,
  input  logic [PixW-1:0]    bg_alpha_i,
  output logic               out_valid_o,
  output logic [PixW-1:0]    out_blue_o,
  output logic [PixW-1:0]    out_green_o,
  output logic [PixW-1:0]    out_red_o,
  output logic [PixW-1:0]    out_alpha_o
);

  logic                    fg_has_alpha_q, bg_has_alpha_q;
  logic                    push, adv;
  entry_t                  f_entry, q_entry;
  q_stat_t                 q_stat;
  logic [NLanes*PixW-1:0]  res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_has_alpha_q <= 1'b1;
      bg_has_alpha_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FG_HAS_ALPHA) begin
        fg_has_alpha_q <= cfg_data_i[0];
      end
      if (cfg_index_i == CFG_BG_HAS_ALPHA) begin
        bg_has_alpha_q <= cfg_data_i[0];
      end
    end
  end

  // The front holds only when the queue is full.
  assign adv  = !q_stat.full;
  assign busy = q_stat.full;

  aoc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (start && !busy),
    .adv_i          (adv),
    .fg_has_alpha_i (fg_has_alpha_q),
    .bg_has_alpha_i (bg_has_alpha_q),
    .in_overlap_i   (in_overlap_i),
    .fg_col_i       ({fg_red_i, fg_green_i, fg_blue_i}),
    .fg_alpha_i     (fg_alpha_i),
    .bg_col_i       ({bg_red_i, bg_green_i, bg_blue_i}),
    .bg_alpha_i     (bg_alpha_i),
    .push_o         (push),
    .entry_o        (f_entry)
  );

  aoc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .pop_i   (q_stat.vld),
    .stat_o  (q_stat),
    .entry_o (q_entry)
  );

  aoc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (q_stat.vld),
    .entry_i (q_entry),
    .vld_o   (out_valid_o),
    .res_o   (res)
  );

  assign out_blue_o  = res[0*PixW +: PixW];
  assign out_green_o = res[1*PixW +: PixW];
  assign out_red_o   = res[2*PixW +: PixW];
  assign out_alpha_o = res[LaneA*PixW +: PixW];

endmodule

>>> sv/aoc_front.sv
// Front part: takes pixel requests, classifies them and forms the weighted sums.
// Depends on aoc_pkg.
`timescale 1ns / 1ps

module aoc_front
  import aoc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  acc_i,
  input  logic                  adv_i,
  input  logic                  fg_has_alpha_i,
  input  logic                  bg_has_alpha_i,
  input  logic                  in_overlap_i,
  input  logic [3*PixW-1:0]     fg_col_i,
  input  logic [PixW-1:0]       fg_alpha_i,
  input  logic [3*PixW-1:0]     bg_col_i,
  input  logic [PixW-1:0]       bg_alpha_i,
  output logic                  push_o,
  output entry_t                entry_o
);

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ZERO,
    KIND_BLEND
  } kind_e;

  // Stage one: effective alphas and raw colors.
  logic              s1_vld_q;
  logic              s1_ovl_q;
  logic [PixW-1:0]   s1_fa_q, s1_ba_q;
  logic [3*PixW-1:0] s1_fc_q, s1_bc_q;

  // Stage two: the two alpha weights.
  logic              s2_vld_q;
  logic              s2_ovl_q, s2_fz_q;
  logic [PixW-1:0]   s2_ba_q;
  logic [DivW-1:0]   s2_wf_q, s2_wb_q;
  logic [3*PixW-1:0] s2_fc_q, s2_bc_q;

  logic [DivW-1:0]   wf_d, wb_d;
  kind_e             kind;
  logic [DivW-1:0]   den;
  logic [DivW:0]     den_rnd;
  logic [2*DivW:0]   alpha_prod;

  assign wf_d = 16'(s1_fa_q * PixMax);
  assign wb_d = 16'(s1_ba_q * (PixMax - s1_fa_q));

  // Control registers of the stage pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= acc_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_ovl_q <= in_overlap_i;
      s1_fa_q  <= fg_has_alpha_i ? fg_alpha_i : PixMax;
      s1_ba_q  <= bg_has_alpha_i ? bg_alpha_i : PixMax;
      s1_fc_q  <= fg_col_i;
      s1_bc_q  <= bg_col_i;
      s2_ovl_q <= s1_ovl_q;
      s2_fz_q  <= (s1_fa_q == '0) && (s1_ba_q == '0);
      s2_ba_q  <= s1_ba_q;
      s2_wf_q  <= wf_d;
      s2_wb_q  <= wb_d;
      s2_fc_q  <= s1_fc_q;
      s2_bc_q  <= s1_bc_q;
    end
  end

  // Classify the pixel.
  always_comb begin
    if (!s2_ovl_q) begin
      kind = KIND_PASS;
    end else if (s2_fz_q) begin
      kind = KIND_ZERO;
    end else begin
      kind = KIND_BLEND;
    end
  end

  assign den = s2_wf_q + s2_wb_q;

  // Output alpha: den / 255 rounded to nearest; 255 is odd, so no exact ties occur.
  assign den_rnd    = {1'b0, den} + HalfPix;
  assign alpha_prod = den_rnd * {1'b0, Rcp255};

  // Build the division jobs; pass-through, zero and alpha lanes divide by one.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      entry_o[c].div = 16'd1;
      entry_o[c].num = '0;
    end
    entry_o[LaneA].div = 16'd1;
    entry_o[LaneA].num = '0;
    case (kind)
      KIND_PASS: begin
        for (int c = 0; c < 3; c++) begin
          entry_o[c].num = NumW'(s2_bc_q[c*PixW +: PixW]);
        end
        entry_o[LaneA].num = NumW'(s2_ba_q);
      end
      KIND_ZERO: begin
        entry_o[LaneA].num = NumW'(PixMax);
      end
      KIND_BLEND: begin
        for (int c = 0; c < 3; c++) begin
          entry_o[c].div = den;
          entry_o[c].num = NumW'(s2_wf_q * s2_fc_q[c*PixW +: PixW]
                               + s2_wb_q * s2_bc_q[c*PixW +: PixW]);
        end
        entry_o[LaneA].num = NumW'(alpha_prod[Rcp255Sh +: PixW]);
      end
      default: begin
        entry_o[LaneA].num = '0;
      end
    endcase
  end

  assign push_o = s2_vld_q && adv_i;

endmodule

>>> sv/aoc_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on aoc_pkg and alpha_over_composite_defines.svh.
`timescale 1ns / 1ps
`include "alpha_over_composite_defines.svh"

module aoc_queue
  import aoc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  entry_i,
  input  logic    pop_i,
  output q_stat_t stat_o,
  output entry_t  entry_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o     = mem_q[rd_ptr_q];
  assign stat_o.vld  = (cnt_q != '0);
  assign stat_o.full = (cnt_q == 2'd2);

  `AOC_ASSERT_IMP(a_no_overflow, push_i, !stat_o.full || pop_i, "queue overflow")
  `AOC_ASSERT_IMP(a_no_underflow, pop_i, stat_o.vld, "queue underflow")
  `AOC_ASSERT_NXT(a_cnt_down, pop_i && !push_i, cnt_q == $past(cnt_q) - 2'd1,
                  "queue count did not drop on pop")

endmodule

>>> sv/aoc_back.sv
// Back part: eight-stage restoring divider on four lanes, then rounding.
// Depends on aoc_pkg.
`timescale 1ns / 1ps

module aoc_back
  import aoc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  entry_t                entry_i,
  output logic                  vld_o,
  output logic [NLanes*PixW-1:0] res_o
);

  localparam int NStg = PixW;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [DivW-1:0] div;
    logic [PixW-1:0] quo;
  } dlane_t;

  typedef dlane_t [NLanes-1:0] dstg_t;

  logic  [NStg:0]             vld_q;
  dstg_t                      stg_q [NStg+1];
  dstg_t                      stg_d [NStg];
  logic  [NLanes*PixW-1:0]    res_q, res_d;

  // One quotient bit per stage, most significant first.
  always_comb begin
    logic [NumW-1:0] trial;
    for (int s = 0; s < NStg; s++) begin
      stg_d[s] = stg_q[s];
      for (int l = 0; l < NLanes; l++) begin
        trial = NumW'(stg_q[s][l].div) << (NStg - 1 - s);
        if (stg_q[s][l].rem >= trial) begin
          stg_d[s][l].rem = stg_q[s][l].rem - trial;
          stg_d[s][l].quo[NStg-1-s] = 1'b1;
        end
      end
    end
  end

  // Round to nearest, ties to even, and saturate.
  always_comb begin
    logic [DivW:0]   twice;
    logic            up;
    logic [PixW:0]   q9;
    for (int l = 0; l < NLanes; l++) begin
      twice = {stg_q[NStg][l].rem[DivW-1:0], 1'b0};
      up = (twice > {1'b0, stg_q[NStg][l].div})
        || ((twice == {1'b0, stg_q[NStg][l].div}) && stg_q[NStg][l].quo[0]);
      q9 = {1'b0, stg_q[NStg][l].quo} + {{PixW{1'b0}}, up};
      res_d[l*PixW +: PixW] = q9[PixW] ? PixMax : q9[PixW-1:0];
    end
  end

  // Valid bits of the divider pipeline and the output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vld_o <= 1'b0;
    end else begin
      vld_q <= {vld_q[NStg-1:0], vld_i};
      vld_o <= vld_q[NStg];
    end
  end

  // Divider payload and output register.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NLanes; l++) begin
      stg_q[0][l].rem <= entry_i[l].num;
      stg_q[0][l].div <= entry_i[l].div;
      stg_q[0][l].quo <= '0;
    end
    for (int s = 0; s < NStg; s++) begin
      stg_q[s+1] <= stg_d[s];
    end
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the alpha-over compositing block.
// Depends on aoc_pkg and the alpha_over_composite RTL; predicts each pixel in place.
`timescale 1ns / 1ps

module testbench;
  import aoc_pkg::*;

  typedef struct {
    logic            overlap;
    logic [PixW-1:0] fg_b, fg_g, fg_r, fg_a;
    logic [PixW-1:0] bg_b, bg_g, bg_r, bg_a;
  } pixel_t;

  typedef struct {
    logic [PixW-1:0] b, g, r, a;
  } blend_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  pixel_t drv = '{default: '0};
  logic out_valid;
  logic [PixW-1:0] out_b, out_g, out_r, out_a;

  pixel_t pixel_queue[$];
  blend_t blend_queue[$];
  logic   fg_alpha_on = 1'b1;
  logic   bg_alpha_on = 1'b1;
  logic   hold_sender = 1'b0;
  int     accepted = 0;
  int     errors = 0;

  alpha_over_composite u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .start(start), .busy(busy),
    .in_overlap_i(drv.overlap),
    .fg_blue_i(drv.fg_b), .fg_green_i(drv.fg_g), .fg_red_i(drv.fg_r), .fg_alpha_i(drv.fg_a),
    .bg_blue_i(drv.bg_b), .bg_green_i(drv.bg_g), .bg_red_i(drv.bg_r), .bg_alpha_i(drv.bg_a),
    .out_valid_o(out_valid),
    .out_blue_o(out_b), .out_green_o(out_g), .out_red_o(out_r), .out_alpha_o(out_a)
  );

  always #6 clk = ~clk;

  // Quotient rounded to nearest with ties to even, clamped to 8 bits.
  function automatic logic [PixW-1:0] round_div(int unsigned n, int unsigned d);
    int unsigned q, r;
    q = n / d;
    r = n % d;
    if (2 * r > d || (2 * r == d && q[0])) q++;
    return (q > 255) ? PixMax : q[PixW-1:0];
  endfunction

  // Straight-alpha over of one pixel under the current alpha enables.
  function automatic blend_t blend_over(pixel_t p);
    blend_t o;
    int unsigned fa, ba, wf, wb, den;
    fa = fg_alpha_on ? p.fg_a : 255;
    ba = bg_alpha_on ? p.bg_a : 255;
    wf = fa * 255;
    wb = ba * (255 - fa);
    den = wf + wb;
    if (!p.overlap) begin
      o = '{p.bg_b, p.bg_g, p.bg_r, ba[PixW-1:0]};
    end else if (den == 0) begin
      o = '{8'd0, 8'd0, 8'd0, PixMax};
    end else begin
      o.b = round_div(wf * p.fg_b + wb * p.bg_b, den);
      o.g = round_div(wf * p.fg_g + wb * p.bg_g, den);
      o.r = round_div(wf * p.fg_r + wb * p.bg_r, den);
      o.a = round_div(den, 255);
    end
    return o;
  endfunction

  // Request driver: presents the next pending pixel at the falling edge.
  always @(negedge clk) begin
    if (rst_n && !hold_sender && pixel_queue.size() > 0 &&
        ((accepted > 500 && accepted < 800) || $urandom_range(99) >= 12)) begin
      start <= 1'b1;
      drv <= pixel_queue[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Acceptance: predict the blend and retire the request.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      blend_queue.push_back(blend_over(drv));
      void'(pixel_queue.pop_front());
      accepted++;
    end
  end

  // Result monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    blend_t e;
    if (rst_n && out_valid) begin
      if (blend_queue.size() == 0) begin
        $display("%0t: unexpected result b=%0d g=%0d r=%0d a=%0d",
                 $time, out_b, out_g, out_r, out_a);
        errors++;
      end else begin
        e = blend_queue.pop_front();
        if (out_b !== e.b) begin
          $display("%0t: blue expected %0d actual %0d", $time, e.b, out_b); errors++;
        end
        if (out_g !== e.g) begin
          $display("%0t: green expected %0d actual %0d", $time, e.g, out_g); errors++;
        end
        if (out_r !== e.r) begin
          $display("%0t: red expected %0d actual %0d", $time, e.r, out_r); errors++;
        end
        if (out_a !== e.a) begin
          $display("%0t: alpha expected %0d actual %0d", $time, e.a, out_a); errors++;
        end
      end
    end
  end

  // Register write; the shadow copy follows the same masking as the block.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_FG_HAS_ALPHA) fg_alpha_on = val[0];
    else if (idx == CFG_BG_HAS_ALPHA) bg_alpha_on = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || blend_queue.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [PixW-1:0] rand_alpha();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return PixMax;
      2: return 8'($urandom_range(3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.overlap = ($urandom_range(9) < 8);
    p.fg_b = 8'($urandom_range(255)); p.fg_g = 8'($urandom_range(255));
    p.fg_r = 8'($urandom_range(255)); p.fg_a = rand_alpha();
    p.bg_b = 8'($urandom_range(255)); p.bg_g = 8'($urandom_range(255));
    p.bg_r = 8'($urandom_range(255)); p.bg_a = rand_alpha();
    return p;
  endfunction

  // Stimulus: directed corners, then random pixels under each alpha setting.
  initial begin
    logic [1:0] modes[4] = '{2'b11, 2'b00, 2'b10, 2'b01};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Both alphas zero, opaque over transparent, pass-through, extremes.
    pixel_queue.push_back('{1'b1, 8'd10, 8'd20, 8'd30, 8'd0, 8'd40, 8'd50, 8'd60, 8'd0});
    pixel_queue.push_back('{1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    pixel_queue.push_back('{1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
    pixel_queue.push_back('{1'b1, 8'd1, 8'd2, 8'd3, 8'd128, 8'd4, 8'd5, 8'd6, 8'd128});
    pixel_queue.push_back('{1'b1, 8'd255, 8'd0, 8'd170, 8'd1, 8'd0, 8'd255, 8'd85, 8'd254});
    pixel_queue.push_back('{1'b1, 8'd0, 8'd255, 8'd1, 8'd1, 8'd255, 8'd0, 8'd254, 8'd1});
    pixel_queue.push_back('{1'b1, 8'd100, 8'd101, 8'd102, 8'd0, 8'd7, 8'd8, 8'd9, 8'd200});
    pixel_queue.push_back('{1'b1, 8'd3, 8'd4, 8'd5, 8'd254, 8'd250, 8'd251, 8'd252, 8'd255});
    pixel_queue.push_back('{1'b1, 8'd1, 8'd0, 8'd1, 8'd127, 8'd0, 8'd1, 8'd0, 8'd2});
    pixel_queue.push_back('{1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd12, 8'd34, 8'd56, 8'd0});
    pixel_queue.push_back('{1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd170, 8'd85, 8'd255});
    pixel_queue.push_back('{1'b0, 8'd170, 8'd85, 8'd1, 8'd9, 8'd0, 8'd0, 8'd0, 8'd77});
    drain();

    // Out-of-range index is ignored; data bits above bit 0 are dropped.
    write_reg(8'd2, 8'hFF);
    write_reg(8'hFF, 8'h00);
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_FG_HAS_ALPHA, {7'($urandom_range(127)), modes[m][1]});
      write_reg(CFG_BG_HAS_ALPHA, {7'($urandom_range(127)), modes[m][0]});
      pixel_queue.push_back('{1'b1, 8'd9, 8'd9, 8'd9, 8'd0, 8'd9, 8'd9, 8'd9, 8'd0});
      pixel_queue.push_back('{1'b0, 8'd9, 8'd9, 8'd9, 8'd0, 8'd1, 8'd2, 8'd3, 8'd0});
      for (int k = 0; k < 320; k++) pixel_queue.push_back(rand_pixel());
      if (m == 0) begin
        // Hold the sender until the pipeline has emptied.
        while (pixel_queue.size() > 200) @(posedge clk);
        hold_sender = 1'b1;
        while (blend_queue.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("alpha_over_composite regression: pass");
    end else begin
      $display("alpha_over_composite regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("alpha_over_composite regression: fail");
    $finish;
  end

endmodule
